@@ rtl/fba_pkg.sv @@
package fba_pkg;

    // Bitmap geometry: one bit per physical frame, packed into 32-bit words.
    localparam int MAX_FRAMES    = 4096;
    localparam int WORD_W        = 8 * 4;
    localparam int WORD_COUNT    = MAX_FRAMES / WORD_W;
    localparam int WORD_IDX_W    = $clog2(WORD_COUNT);
    localparam int WORD_CNT_W    = $clog2(WORD_COUNT + 1);
    localparam int BIT_IDX_W     = $clog2(WORD_W);

    // Field widths of the page entry and the frame count register.
    localparam int FRAME_W       = 12;
    localparam int FCOUNT_W      = 13;
    localparam int STATUS_W      = 2;

    // The frame field can only name frames below this limit.
    localparam int FRAME_FIELD_LIMIT = 32'h1000;
    localparam int FRAME_LIMIT   = (MAX_FRAMES < FRAME_FIELD_LIMIT) ?
                                   MAX_FRAMES : FRAME_FIELD_LIMIT;

    localparam logic [WORD_W-1:0]   FULL_WORD    = 32'hFFFF_FFFF;
    localparam logic [FCOUNT_W-1:0] FCOUNT_RESET = 13'd4096;

    // Operation codes carried by the mode field.
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FREE_MOD,
        ST_RESULT
    } state_t;

    // Request from the sequencer to the bitmap memory.
    typedef struct packed {
        logic                  rd_en;
        logic [WORD_IDX_W-1:0] rd_addr;
        logic                  wr_en;
        logic [WORD_IDX_W-1:0] wr_addr;
        logic [WORD_W-1:0]     wr_data;
    } ram_req_t;

    // One finished result transaction.
    typedef struct packed {
        logic [FRAME_W-1:0]  frame_out;
        logic                present_bit;
        logic                write_bit;
        logic                user_bit;
        logic [STATUS_W-1:0] status;
    } result_t;

    // Position of the lowest clear bit of a word that is not full.
    function automatic logic [BIT_IDX_W-1:0] lowest_zero(input logic [WORD_W-1:0] word);
        logic [BIT_IDX_W-1:0] pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!word[i]) begin
                pos = BIT_IDX_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

@@ rtl/fba_bitmap_ram.sv @@
module fba_bitmap_ram (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  fba_pkg::ram_req_t                    req,
    output logic [fba_pkg::WORD_W-1:0]           rd_data
);

    logic [fba_pkg::WORD_W-1:0]     words_mem [fba_pkg::WORD_COUNT];
    logic [fba_pkg::WORD_COUNT-1:0] vld_reg;
    logic [fba_pkg::WORD_W-1:0]     rd_data_reg;
    logic                           rd_vld_reg;

    // Word storage with a registered read.
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            words_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= words_mem[req.rd_addr];
        end
    end

    // A word never written since reset reads as all frames free.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_vld_reg <= vld_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

@@ rtl/fba_ctrl.sv @@
module fba_ctrl (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 mode,
    input  logic [fba_pkg::FRAME_W-1:0]          frame_in,
    input  logic                                 kernel_page,
    input  logic                                 writable_page,
    input  logic [fba_pkg::FCOUNT_W-1:0]         frame_count,
    output fba_pkg::ram_req_t                    ram_req,
    input  logic [fba_pkg::WORD_W-1:0]           ram_rdata,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output fba_pkg::result_t                     res
);

    fba_pkg::state_t                     state_reg, state_next;
    logic                                user_reg, user_next;
    logic                                write_reg, write_next;
    logic [fba_pkg::FRAME_W-1:0]         frame_reg, frame_next;
    logic [fba_pkg::WORD_IDX_W-1:0]      chk_reg, chk_next;
    logic [fba_pkg::WORD_CNT_W-1:0]      words_reg, words_next;
    fba_pkg::result_t                    res_reg, res_next;

    logic [fba_pkg::FCOUNT_W-1:0]        fcount_lim;
    logic [fba_pkg::WORD_CNT_W-1:0]      managed_words;
    logic [fba_pkg::WORD_CNT_W-1:0]      chk_plus;
    logic                                word_hit;
    logic                                last_word;
    logic [fba_pkg::BIT_IDX_W-1:0]       free_bit;
    logic [fba_pkg::WORD_IDX_W-1:0]      free_word;
    logic [fba_pkg::BIT_IDX_W-1:0]       rel_bit;

    // Number of whole words under management, limited to what the bitmap holds.
    assign fcount_lim = (frame_count > fba_pkg::FCOUNT_W'(fba_pkg::FRAME_LIMIT)) ?
                        fba_pkg::FCOUNT_W'(fba_pkg::FRAME_LIMIT) : frame_count;
    assign managed_words = fba_pkg::WORD_CNT_W'(fcount_lim >> fba_pkg::BIT_IDX_W);

    // Scan of the word returned by the memory this cycle.
    assign chk_plus  = fba_pkg::WORD_CNT_W'(chk_reg) + 1'b1;
    assign word_hit  = (ram_rdata != fba_pkg::FULL_WORD);
    assign last_word = (chk_plus == words_reg);
    assign free_bit  = fba_pkg::lowest_zero(ram_rdata);

    // Word and bit of the frame being released.
    assign free_word = frame_reg[fba_pkg::FRAME_W-1:fba_pkg::BIT_IDX_W];
    assign rel_bit   = frame_reg[fba_pkg::BIT_IDX_W-1:0];

    assign in_ready  = (state_reg == fba_pkg::ST_IDLE);
    assign res_valid = (state_reg == fba_pkg::ST_RESULT);
    assign res       = res_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fba_pkg::ST_IDLE: begin
                if (in_valid) begin
                    if (mode == fba_pkg::MODE_ALLOC) begin
                        if ((frame_in != '0) || (managed_words == '0)) begin
                            state_next = fba_pkg::ST_RESULT;
                        end else begin
                            state_next = fba_pkg::ST_SCAN;
                        end
                    end else if (frame_in == '0) begin
                        state_next = fba_pkg::ST_RESULT;
                    end else begin
                        state_next = fba_pkg::ST_FREE_MOD;
                    end
                end
            end
            fba_pkg::ST_SCAN: begin
                if (word_hit || last_word) begin
                    state_next = fba_pkg::ST_RESULT;
                end
            end
            fba_pkg::ST_FREE_MOD: begin
                state_next = fba_pkg::ST_RESULT;
            end
            fba_pkg::ST_RESULT: begin
                if (res_ready) begin
                    state_next = fba_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fba_pkg::ST_IDLE;
            end
        endcase
    end

    // Memory requests and result formation for each state.
    always_comb begin
        user_next  = user_reg;
        write_next = write_reg;
        frame_next = frame_reg;
        chk_next   = chk_reg;
        words_next = words_reg;
        res_next   = res_reg;
        ram_req    = '0;
        unique case (state_reg)
            fba_pkg::ST_IDLE: begin
                if (in_valid) begin
                    user_next  = ~kernel_page;
                    write_next = writable_page;
                    frame_next = frame_in;
                    chk_next   = '0;
                    words_next = managed_words;
                    res_next   = '0;
                    if (mode == fba_pkg::MODE_ALLOC) begin
                        if (frame_in != '0) begin
                            res_next.frame_out = frame_in;
                            res_next.status    = fba_pkg::STATUS_IGNORED;
                        end else if (managed_words == '0) begin
                            res_next.status    = fba_pkg::STATUS_NO_FREE;
                        end else begin
                            ram_req.rd_en   = 1'b1;
                            ram_req.rd_addr = '0;
                        end
                    end else if (frame_in == '0) begin
                        res_next.status = fba_pkg::STATUS_IGNORED;
                    end else begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = frame_in[fba_pkg::FRAME_W-1:fba_pkg::BIT_IDX_W];
                    end
                end
            end
            fba_pkg::ST_SCAN: begin
                if (word_hit) begin
                    // Claim the lowest free frame of this word.
                    ram_req.wr_en       = 1'b1;
                    ram_req.wr_addr     = chk_reg;
                    ram_req.wr_data     = ram_rdata |
                                          (fba_pkg::WORD_W'(1) << free_bit);
                    res_next.frame_out  = {chk_reg, free_bit};
                    res_next.present_bit = 1'b1;
                    res_next.write_bit  = write_reg;
                    res_next.user_bit   = user_reg;
                    res_next.status     = fba_pkg::STATUS_DONE;
                end else if (last_word) begin
                    res_next.status = fba_pkg::STATUS_NO_FREE;
                end else begin
                    // Fetch the following word while this one is checked.
                    chk_next        = chk_plus[fba_pkg::WORD_IDX_W-1:0];
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = chk_plus[fba_pkg::WORD_IDX_W-1:0];
                end
            end
            fba_pkg::ST_FREE_MOD: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = free_word;
                ram_req.wr_data = ram_rdata & ~(fba_pkg::WORD_W'(1) << rel_bit);
                res_next        = '0;
                res_next.status = fba_pkg::STATUS_DONE;
            end
            fba_pkg::ST_RESULT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fba_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        user_reg  <= user_next;
        write_reg <= write_next;
        frame_reg <= frame_next;
        chk_reg   <= chk_next;
        words_reg <= words_next;
        res_reg   <= res_next;
    end

    // The bitmap is written only by a successful claim or a release.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_req.wr_en |-> (state_reg == fba_pkg::ST_SCAN) ||
                          (state_reg == fba_pkg::ST_FREE_MOD))
        else $error("bitmap write outside claim or release");

    // A claim sets exactly one bit that was clear.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_req.wr_en && (state_reg == fba_pkg::ST_SCAN)) |->
            ($countones(ram_req.wr_data) == $countones(ram_rdata) + 1))
        else $error("claim did not set exactly one free bit");

    // The scan never runs past the managed words.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fba_pkg::ST_SCAN) |->
            (fba_pkg::WORD_CNT_W'(chk_reg) < words_reg))
        else $error("scan beyond managed words");

    // A failed allocation reports no frame and a clear present bit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == fba_pkg::ST_RESULT) &&
         (res_reg.status == fba_pkg::STATUS_NO_FREE)) |->
            ((res_reg.frame_out == '0) && !res_reg.present_bit))
        else $error("no-free result carries a frame");

endmodule

@@ rtl/frame_bitmap_allocator.sv @@
// First-fit physical frame allocator over a bitmap held in a 128 x 32-bit memory,
// one bit per frame, all frames free after reset. An allocation (mode 0) on an
// unmapped page scans the managed words from word 0 upward at one word per cycle
// through the single read port of the bitmap memory, then sets the lowest clear
// bit. A free (mode 1) is one read-modify-write. One request is processed at a
// time, and a new input transaction is taken while the previous result still
// waits in the output register. Every request produces exactly one result
// transaction. The user must write frame_count through cfg_wr_en and cfg_wr_data
// only while the block is idle; the block itself does not enforce this.
module frame_bitmap_allocator (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [fba_pkg::FCOUNT_W-1:0]         cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_mode,
    input  logic [fba_pkg::FRAME_W-1:0]          s_frame_in,
    input  logic                                 s_kernel_page,
    input  logic                                 s_writable_page,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [fba_pkg::FRAME_W-1:0]          m_frame_out,
    output logic                                 m_present_bit,
    output logic                                 m_write_bit,
    output logic                                 m_user_bit,
    output logic [fba_pkg::STATUS_W-1:0]         m_status
);

    logic [fba_pkg::FCOUNT_W-1:0] frame_count_reg;
    fba_pkg::ram_req_t            ram_req;
    logic [fba_pkg::WORD_W-1:0]   ram_rdata;
    logic                         res_valid;
    logic                         res_ready;
    fba_pkg::result_t             res;
    logic                         out_valid_reg, out_valid_next;
    fba_pkg::result_t             out_reg, out_next;

    // Frame count register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg <= fba_pkg::FCOUNT_RESET;
        end else if (cfg_wr_en) begin
            frame_count_reg <= cfg_wr_data;
        end
    end

    fba_bitmap_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ram_req),
        .rd_data (ram_rdata)
    );

    fba_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .mode          (s_mode),
        .frame_in      (s_frame_in),
        .kernel_page   (s_kernel_page),
        .writable_page (s_writable_page),
        .frame_count   (frame_count_reg),
        .ram_req       (ram_req),
        .ram_rdata     (ram_rdata),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res)
    );

    // Output register: takes a result whenever it is empty or being drained.
    assign res_ready = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_frame_out   = out_reg.frame_out;
    assign m_present_bit = out_reg.present_bit;
    assign m_write_bit   = out_reg.write_bit;
    assign m_user_bit    = out_reg.user_bit;
    assign m_status      = out_reg.status;

endmodule
